/* src/ctc_pkg.sv */
// shared types and constants for the columnar transposition cipher
package ctc_pkg;

    // default sizes
    localparam int unsigned MAX_CHARS_DEF   = 64;
    localparam int unsigned MAX_COLUMNS_DEF = 9;

    // field widths
    localparam int unsigned KEY_W  = 30;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned NDIG   = 10;

    // divide by ten through a reciprocal: q = (v * RECIP) >> RECIP_SH
    localparam int unsigned   RECIP_W  = 32;
    localparam int unsigned   RECIP_SH = 35;
    localparam logic [31:0]   RECIP    = 32'hCCCC_CCCD;

    // padding byte '?'
    localparam logic [CHAR_W-1:0] PAD_BYTE = 8'h3F;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    // reset key: a single column
    localparam logic [KEY_W-1:0] KEY_RESET = 30'd1;

    // key decoder status back to the sequencer
    typedef struct packed {
        logic             done;
        logic             bad;
        logic [DIG_W-1:0] cols;
    } t_kd_status;

endpackage

/* src/columnar_transposition_cipher.sv */
// top level of the columnar transposition cipher: byte store, sizing and readout
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_char_in, i_last_char
//  output    out        o_valid / i_ready     o_char_out, o_last_out, o_overflow, o_bad_key
//  config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// the final byte starts key decoding (a multiply and a fix step per key digit on the
// divide-by-ten multiplier, then a check step per digit); a good key then starts grid
// sizing (a step per row on the add and compare), and each output byte passes the
// address, data and output states on the multiply-add and the registered store read.
// no new byte is taken until the last output transaction of the burst completes.
// reset is synchronous and active low; the key returns to one column, encrypt mode.
// an output transaction held by i_ready low simply waits in the output register.
module columnar_transposition_cipher #(
    parameter int unsigned MAX_CHARS   = ctc_pkg::MAX_CHARS_DEF,
    parameter int unsigned MAX_COLUMNS = ctc_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ctc_pkg::CHAR_W-1:0]        i_char_in,
    input  logic                              i_last_char,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ctc_pkg::CHAR_W-1:0]        o_char_out,
    output logic                              o_last_out,
    output logic                              o_overflow,
    output logic                              o_bad_key,
    input  logic                              i_cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctc_pkg::KEY_W-1:0]         i_cfg_data
);

    import ctc_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CHARS);
    localparam int unsigned CW = $clog2(MAX_CHARS + 1);
    localparam int unsigned JW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned SW = ((CW > DIG_W) ? CW : DIG_W) + 1;
    localparam int unsigned MW = SW + DIG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_SIZE,
        S_ADDR,
        S_DATA,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [KEY_W-1:0]  r_key;
    logic              r_decrypt;
    logic [CW-1:0]     r_cnt;
    logic              r_drop;
    logic              r_kd_start;
    logic [DIG_W-1:0]  r_ncol;
    logic [CW-1:0]     r_acc;
    logic [CW-1:0]     r_rows;
    logic [CW-1:0]     r_i;
    logic [JW-1:0]     r_j;
    logic [CW-1:0]     r_addr;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_ovf;
    logic              r_bad;

    t_kd_status        kd_status;
    logic [DIG_W-1:0]  kd_order;
    logic [DIG_W-1:0]  kd_rank;
    logic [CHAR_W-1:0] ram_q;
    logic              in_acc;
    logic              out_acc;
    logic              ram_we;
    logic [SW-1:0]     acc_sum;
    logic              row_end;
    logic              col_end;
    logic [CW-1:0]     mul_wide;
    logic [DIG_W-1:0]  mul_narrow;
    logic [MW-1:0]     mul_add;
    logic [MW-1:0]     mul_res;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign ram_we  = in_acc && (r_cnt < CW'(MAX_CHARS));

    // message store
    ctc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_char_in),
        .i_raddr (mul_res[AW-1:0]),
        .o_rdata (ram_q)
    );

    // key digits to column maps
    ctc_key_decode #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_keydec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kd_start),
        .i_key    (r_key),
        .i_sel    (r_j),
        .o_status (kd_status),
        .o_order  (kd_order),
        .o_rank   (kd_rank)
    );

    // grid sizing adder and loop ends
    always_comb begin
        acc_sum = SW'(r_acc) + SW'(r_ncol);
        row_end = (r_i == r_rows - CW'(1));
        col_end = (DIG_W'(r_j) == r_ncol - DIG_W'(1));
    end

    // shared address unit: row * columns + column order, or column rank * rows + row
    always_comb begin
        if (r_decrypt) begin
            mul_wide   = r_rows;
            mul_narrow = kd_rank;
            mul_add    = MW'(r_i);
        end else begin
            mul_wide   = r_i;
            mul_narrow = r_ncol;
            mul_add    = MW'(kd_order);
        end
        mul_res = MW'(mul_wide) * MW'(mul_narrow) + mul_add;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= KEY_RESET;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY:  r_key     <= i_cfg_data;
                CFG_MODE: r_decrypt <= i_cfg_data[0];
                default:  r_key     <= r_key;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_drop     <= 1'b0;
            r_kd_start <= 1'b0;
        end else begin
            r_kd_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (ram_we) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_char) begin
                            r_kd_start <= 1'b1;
                            r_state    <= S_KEY;
                        end
                    end
                end
                S_KEY: begin
                    if (kd_status.done) begin
                        if (kd_status.bad) begin
                            r_char  <= '0;
                            r_last  <= 1'b1;
                            r_ovf   <= r_drop;
                            r_bad   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_ncol  <= kd_status.cols;
                            r_acc   <= '0;
                            r_rows  <= '0;
                            r_state <= S_SIZE;
                        end
                    end
                end
                S_SIZE: begin
                    if (r_acc >= r_cnt) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (r_cnt == '0) begin
                            r_char  <= '0;
                            r_last  <= 1'b1;
                            r_ovf   <= 1'b1;
                            r_bad   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ADDR;
                        end
                    end else if (acc_sum > SW'(MAX_CHARS)) begin
                        // grid too large: cut to whole rows that fit
                        r_cnt  <= r_acc;
                        r_drop <= 1'b1;
                    end else begin
                        r_acc  <= CW'(acc_sum);
                        r_rows <= r_rows + CW'(1);
                    end
                end
                S_ADDR: begin
                    r_addr  <= CW'(mul_res);
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_char  <= (r_addr < r_cnt) ? ram_q : PAD_BYTE;
                    r_last  <= row_end && col_end;
                    r_ovf   <= r_drop;
                    r_bad   <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_last) begin
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ADDR;
                            if (r_decrypt) begin
                                if (col_end) begin
                                    r_j <= '0;
                                    r_i <= r_i + CW'(1);
                                end else begin
                                    r_j <= r_j + JW'(1);
                                end
                            end else begin
                                if (row_end) begin
                                    r_i <= '0;
                                    r_j <= r_j + JW'(1);
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_char_out = r_char;
    assign o_last_out = r_last;
    assign o_overflow = r_ovf;
    assign o_bad_key  = r_bad;

    // the store count never passes its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CHARS))
        else $error("byte count beyond store depth");

    // no byte is taken while a result is on offer
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output offered together");

    // every read address lies inside the store
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_addr < CW'(MAX_CHARS)))
        else $error("grid address beyond store");

    // the final transaction of a burst frees the input side
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_out) |=> (o_ready && (r_cnt == '0) && !r_drop))
        else $error("store not cleared after burst");

endmodule

/* src/ctc_ram.sv */
// generic single write port ram with registered read
module ctc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ctc_key_decode.sv */
// key decoder: splits the decimal key into digits and builds the column maps
module ctc_key_decode #(
    parameter int unsigned MAX_COLUMNS = ctc_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic [ctc_pkg::KEY_W-1:0]                             i_key,
    input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] i_sel,
    output ctc_pkg::t_kd_status                                   o_status,
    output logic [ctc_pkg::DIG_W-1:0]                             o_order,
    output logic [ctc_pkg::DIG_W-1:0]                             o_rank
);

    import ctc_pkg::*;

    localparam int unsigned JW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned PR_W = KEY_W + RECIP_W;
    localparam int unsigned Q_W  = PR_W - RECIP_SH;

    typedef enum logic [1:0] {
        K_IDLE,
        K_MUL,
        K_FIX,
        K_CHECK
    } t_kstate;

    t_kstate          r_state;
    logic [KEY_W-1:0] r_v;
    logic [PR_W-1:0]  r_prod;
    logic [DIG_W-1:0] r_n;
    logic [DIG_W-1:0] r_t;
    logic [DIG_W-1:0] r_dig [NDIG];
    logic [MAX_COLUMNS-1:0] r_seen;
    logic [DIG_W-1:0] r_order [MAX_COLUMNS];
    logic [DIG_W-1:0] r_rank  [MAX_COLUMNS];
    logic             r_done;
    logic             r_bad;

    logic [Q_W-1:0]   q;
    logic [KEY_W-1:0] q10;
    logic [KEY_W-1:0] rem;
    logic [DIG_W-1:0] n_n;
    logic [DIG_W-1:0] d;
    logic [DIG_W-1:0] dm1;
    logic [DIG_W-1:0] pos;
    logic             dig_ok;

    // quotient and remainder of one digit step
    always_comb begin
        q   = r_prod[PR_W-1:RECIP_SH];
        q10 = (KEY_W'(q) << 3) + (KEY_W'(q) << 1);
        rem = r_v - q10;
        n_n = r_n + DIG_W'(1);
    end

    // digit check: non zero, within count, not seen before
    always_comb begin
        d      = r_dig[r_t];
        dm1    = d - DIG_W'(1);
        pos    = r_n - DIG_W'(1) - r_t;
        dig_ok = 1'b0;
        if ((d != '0) && (d <= r_n)) begin
            dig_ok = !r_seen[dm1[JW-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
            r_done  <= 1'b0;
            r_bad   <= 1'b0;
            r_n     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                K_IDLE: begin
                    if (i_start) begin
                        r_v <= i_key;
                        r_n <= '0;
                        if (i_key == '0) begin
                            r_done <= 1'b1;
                            r_bad  <= 1'b1;
                        end else begin
                            r_state <= K_MUL;
                        end
                    end
                end
                K_MUL: begin
                    r_prod  <= PR_W'(r_v) * PR_W'(RECIP);
                    r_state <= K_FIX;
                end
                K_FIX: begin
                    r_dig[r_n] <= rem[DIG_W-1:0];
                    r_n        <= n_n;
                    r_v        <= KEY_W'(q);
                    if (q == '0) begin
                        if (n_n > DIG_W'(MAX_COLUMNS)) begin
                            r_done  <= 1'b1;
                            r_bad   <= 1'b1;
                            r_state <= K_IDLE;
                        end else begin
                            r_t     <= '0;
                            r_seen  <= '0;
                            r_state <= K_CHECK;
                        end
                    end else begin
                        r_state <= K_MUL;
                    end
                end
                K_CHECK: begin
                    if (!dig_ok) begin
                        r_done  <= 1'b1;
                        r_bad   <= 1'b1;
                        r_state <= K_IDLE;
                    end else begin
                        r_seen[dm1[JW-1:0]]  <= 1'b1;
                        r_order[dm1[JW-1:0]] <= pos;
                        r_rank[pos[JW-1:0]]  <= dm1;
                        if (r_t == r_n - DIG_W'(1)) begin
                            r_done  <= 1'b1;
                            r_bad   <= 1'b0;
                            r_state <= K_IDLE;
                        end else begin
                            r_t <= r_t + DIG_W'(1);
                        end
                    end
                end
                default: r_state <= K_IDLE;
            endcase
        end
    end

    assign o_status.done = r_done;
    assign o_status.bad  = r_bad;
    assign o_status.cols = r_n;
    assign o_order       = r_order[i_sel];
    assign o_rank        = r_rank[i_sel];

    // a good key never has more columns than the maps hold
    a_cols_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_bad) |-> (r_n != '0) && (r_n <= DIG_W'(MAX_COLUMNS)))
        else $error("good key with column count out of range");

    // digit extraction leaves a single decimal digit
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == K_FIX) |-> (rem < KEY_W'(10)))
        else $error("digit step remainder not below ten");

endmodule
